[sv/lrdv_pkg.sv]
package lrdv_pkg;

    localparam int HEADER_BYTES = 13;
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    // register indexes on the configuration port
    localparam logic [1:0] REG_MAGIC = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;
    localparam logic [1:0] REG_KNOWN_SIZE = 2'd2;

    localparam logic RESULT_RECORD = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] rec_offset;
        logic [31:0] payload_length;
        logic        size_known;
        logic        torn_found;
        logic [31:0] torn_count;
        logic [31:0] clean_end;
        logic        last;
    } lrdv_result_t;

    // reflected CRC-32C, one byte per call
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/log_record_deframer_validator.sv]
// Log record deframer and CRC-32C validator.
// Input channel (in_valid / in_stall): one word per cycle while in_stall is low,
// carrying data_byte, byte_valid and segment_end. A word with byte_valid low and
// segment_end high just closes the segment; a word with both low is ignored.
// Output channel (out_valid / out_stall): the results of each word handed over,
// either a good record (offset, payload length, size_known) or, at segment end,
// a summary (torn flag, torn byte count, clean end offset). last_of_item marks
// the final result caused by one input word; a word gives at most two.
// Flow: an accepted word is registered, processed once the result queue has room
// and its results are written to the queue, from which the receiver takes them.
// Throughput: one byte per cycle while the result queue has room, set by the
// byte-wide CRC-32C update and the header field capture in the single processing stage.
// A four-entry result queue sits between the sides; the input stalls only
// while more than two results wait, so a stalled receiver backs up the input
// after a few words and nothing is lost. Reset: magic 0, version 1, known
// size 0; the parser starts a fresh segment in header phase at offset zero.
// Configuration is for the user to write while the block is idle (not enforced).
module log_record_deframer_validator
    import lrdv_pkg::*;
#(
    parameter int OFFSET_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        segment_end,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [31:0] rec_offset,
    output logic [31:0] payload_length,
    output logic        size_known,
    output logic        torn_found,
    output logic [31:0] torn_count,
    output logic [31:0] clean_end,
    output logic        last_of_item
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_STOPPED = 2'd2;

    localparam logic [3:0] IDX_VERSION = 4'd4;
    localparam logic [3:0] IDX_LEN_FIRST = 4'd5;
    localparam logic [3:0] IDX_CRC_FIRST = 4'd9;
    localparam logic [3:0] IDX_LAST = 4'(HEADER_BYTES - 1);

    localparam int FIFO_DEPTH = 4;

    // configuration
    logic [31:0] cfg_magic_reg;
    logic [7:0]  cfg_version_reg;
    logic [15:0] cfg_known_reg;

    // input stage
    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;
    logic        stage_has_byte_reg;
    logic        stage_end_reg;
    logic        stage_go;

    // parser state
    logic [1:0]             phase_reg, phase_next;
    logic [3:0]             hdr_idx_reg, hdr_idx_next;
    logic [31:0]            hdr_magic_reg, hdr_magic_next;
    logic [7:0]             hdr_version_reg, hdr_version_next;
    logic [31:0]            hdr_length_reg, hdr_length_next;
    logic [31:0]            hdr_crc_reg, hdr_crc_next;
    logic [31:0]            run_crc_reg, run_crc_next;
    logic [31:0]            payload_left_reg, payload_left_next;
    logic [OFFSET_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [OFFSET_BITS-1:0] record_start_reg, record_start_next;

    logic [1:0]             len_lane;
    logic [1:0]             crc_lane;
    logic                   finish;
    logic                   rec_hit;
    logic [OFFSET_BITS-1:0] torn_bytes;

    lrdv_result_t           res0, res1, rec_res, sum_res;
    logic [1:0]             push_cnt;

    // result queue
    lrdv_result_t           fifo_mem [FIFO_DEPTH];
    logic [1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [2:0]             count_reg;
    logic                   pop;

    assign stage_go = stage_valid_reg && (count_reg <= 3'(FIFO_DEPTH - 2));
    assign in_stall = stage_valid_reg && !(count_reg <= 3'(FIFO_DEPTH - 2));
    assign len_lane = 2'(hdr_idx_reg - IDX_LEN_FIRST);
    assign crc_lane = 2'(hdr_idx_reg - IDX_CRC_FIRST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_magic_reg   <= '0;
            cfg_version_reg <= 8'd1;
            cfg_known_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MAGIC:      cfg_magic_reg <= cfg_data;
                REG_VERSION:    cfg_version_reg <= cfg_data[7:0];
                REG_KNOWN_SIZE: cfg_known_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            stage_byte_reg     <= data_byte;
            stage_has_byte_reg <= byte_valid;
            stage_end_reg      <= segment_end;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        hdr_idx_next      = hdr_idx_reg;
        hdr_magic_next    = hdr_magic_reg;
        hdr_version_next  = hdr_version_reg;
        hdr_length_next   = hdr_length_reg;
        hdr_crc_next      = hdr_crc_reg;
        run_crc_next      = run_crc_reg;
        payload_left_next = payload_left_reg;
        bytes_seen_next   = bytes_seen_reg;
        record_start_next = record_start_reg;
        finish            = 1'b0;
        rec_hit           = 1'b0;

        if (stage_has_byte_reg)
        begin
            bytes_seen_next = bytes_seen_reg + OFFSET_BITS'(1);
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_idx_reg < IDX_VERSION)
                    begin
                        hdr_magic_next[8*hdr_idx_reg[1:0] +: 8] = stage_byte_reg;
                    end
                    else if (hdr_idx_reg == IDX_VERSION)
                    begin
                        hdr_version_next = stage_byte_reg;
                        run_crc_next = crc32c_byte(run_crc_reg, stage_byte_reg);
                    end
                    else if (hdr_idx_reg < IDX_CRC_FIRST)
                    begin
                        hdr_length_next[8*len_lane +: 8] = stage_byte_reg;
                        run_crc_next = crc32c_byte(run_crc_reg, stage_byte_reg);
                    end
                    else
                    begin
                        hdr_crc_next[8*crc_lane +: 8] = stage_byte_reg;
                    end
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                    if (hdr_idx_reg == IDX_LAST)
                    begin
                        if (hdr_magic_next != cfg_magic_reg
                            || hdr_version_next != cfg_version_reg)
                        begin
                            phase_next = PH_STOPPED;
                        end
                        else if (hdr_length_next == '0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            payload_left_next = hdr_length_next;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    run_crc_next = crc32c_byte(run_crc_reg, stage_byte_reg);
                    payload_left_next = payload_left_reg - 32'd1;
                    if (payload_left_next == '0)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    // stopped: only count the byte
                end
            endcase

            if (finish)
            begin
                if ((run_crc_next ^ CRC_ONES) != hdr_crc_next)
                begin
                    phase_next = PH_STOPPED;
                end
                else
                begin
                    rec_hit           = 1'b1;
                    record_start_next = bytes_seen_next;
                    phase_next        = PH_HEADER;
                    hdr_idx_next      = '0;
                    hdr_magic_next    = '0;
                    hdr_version_next  = '0;
                    hdr_crc_next      = '0;
                    run_crc_next      = CRC_ONES;
                    payload_left_next = '0;
                end
            end
        end

        // record result uses the length before the header fields are cleared
        rec_res                = '0;
        rec_res.kind           = RESULT_RECORD;
        rec_res.rec_offset     = 32'(record_start_reg);
        rec_res.payload_length = hdr_length_next;
        rec_res.size_known     = (hdr_length_next == 32'(cfg_known_reg));
        rec_res.last           = !stage_end_reg;
        if (rec_hit)
        begin
            hdr_length_next = '0;
        end

        torn_bytes         = bytes_seen_next - record_start_next;
        sum_res            = '0;
        sum_res.kind       = RESULT_SUMMARY;
        sum_res.torn_found = (torn_bytes != '0);
        sum_res.torn_count = 32'(torn_bytes);
        sum_res.clean_end  = 32'(record_start_next);
        sum_res.last       = 1'b1;

        if (stage_end_reg)
        begin
            phase_next        = PH_HEADER;
            hdr_idx_next      = '0;
            hdr_magic_next    = '0;
            hdr_version_next  = '0;
            hdr_length_next   = '0;
            hdr_crc_next      = '0;
            run_crc_next      = CRC_ONES;
            payload_left_next = '0;
            bytes_seen_next   = '0;
            record_start_next = '0;
        end

        res0 = rec_hit ? rec_res : sum_res;
        res1 = sum_res;
        push_cnt = 2'(rec_hit) + 2'(stage_end_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            hdr_idx_reg      <= '0;
            hdr_magic_reg    <= '0;
            hdr_version_reg  <= '0;
            hdr_length_reg   <= '0;
            hdr_crc_reg      <= '0;
            run_crc_reg      <= CRC_ONES;
            payload_left_reg <= '0;
            bytes_seen_reg   <= '0;
            record_start_reg <= '0;
        end
        else if (stage_go)
        begin
            phase_reg        <= phase_next;
            hdr_idx_reg      <= hdr_idx_next;
            hdr_magic_reg    <= hdr_magic_next;
            hdr_version_reg  <= hdr_version_next;
            hdr_length_reg   <= hdr_length_next;
            hdr_crc_reg      <= hdr_crc_next;
            run_crc_reg      <= run_crc_next;
            payload_left_reg <= payload_left_next;
            bytes_seen_reg   <= bytes_seen_next;
            record_start_reg <= record_start_next;
        end
    end

    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (stage_go)
        begin
            if (push_cnt != 2'd0)
            begin
                fifo_mem[wr_ptr_reg] <= res0;
            end
            if (push_cnt == 2'd2)
            begin
                fifo_mem[wr_ptr_reg + 2'd1] <= res1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (stage_go)
            begin
                wr_ptr_reg <= wr_ptr_reg + push_cnt;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (stage_go ? 3'(push_cnt) : 3'd0) - 3'(pop);
        end
    end

    assign out_valid      = (count_reg != 3'd0);
    assign result_kind    = fifo_mem[rd_ptr_reg].kind;
    assign rec_offset     = fifo_mem[rd_ptr_reg].rec_offset;
    assign payload_length = fifo_mem[rd_ptr_reg].payload_length;
    assign size_known     = fifo_mem[rd_ptr_reg].size_known;
    assign torn_found     = fifo_mem[rd_ptr_reg].torn_found;
    assign torn_count     = fifo_mem[rd_ptr_reg].torn_count;
    assign clean_end      = fifo_mem[rd_ptr_reg].clean_end;
    assign last_of_item   = fifo_mem[rd_ptr_reg].last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_header_index: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= 4'(HEADER_BYTES))
        else $error("header index past header length");

    a_segment_reset: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && stage_end_reg |=> bytes_seen_reg == '0 && record_start_reg == '0
        && phase_reg == PH_HEADER)
        else $error("parser not restarted after segment end");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !stage_go |=> stage_valid_reg && $stable(stage_end_reg))
        else $error("held input word lost");

endmodule
